/* hdl/lvpp_pkg.sv */
// ----------------------------------------------------------------------------
// lvpp_pkg
// Types and constants of the line vector packet parser: header codes,
// register indexes, parse phases and the result record.
// ----------------------------------------------------------------------------
package lvpp_pkg;

    // header bytes of a response packet
    localparam logic [7:0] SYNC_A        = 8'haf;
    localparam logic [7:0] SYNC_B        = 8'hc1;
    localparam logic [7:0] RESP_TYPE     = 8'd49;
    localparam logic [8:0] PAYLOAD_START = 9'd6;

    // header byte positions
    localparam logic [8:0] POS_SYNC_A = 9'd0;
    localparam logic [8:0] POS_SYNC_B = 9'd1;
    localparam logic [8:0] POS_TYPE   = 9'd2;
    localparam logic [8:0] POS_LENGTH = 9'd3;
    localparam logic [8:0] POS_HDR_END = 9'd5;

    // vector byte slots
    localparam logic [2:0] SLOT_START_X = 3'd0;
    localparam logic [2:0] SLOT_START_Y = 3'd1;
    localparam logic [2:0] SLOT_END_X   = 3'd2;
    localparam logic [2:0] SLOT_END_Y   = 3'd3;
    localparam logic [2:0] SLOT_INDEX   = 3'd4;
    localparam logic [2:0] SLOT_FLAGS   = 3'd5;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_LINE_FEATURE_TYPE = 2'd0,
        REG_FRAME_HEIGHT      = 2'd1,
        REG_MAX_VECTORS       = 2'd2
    } reg_index_t;

    localparam logic [7:0] LINE_FEATURE_TYPE_RST = 8'd1;
    localparam logic [7:0] FRAME_HEIGHT_RST      = 8'd52;
    localparam logic [7:0] MAX_VECTORS_RST       = 8'd100;

    // result kinds
    localparam logic KIND_VECTOR  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // packet status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_HDR  = 1'b1;

    // parse phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_FTYPE  = 5'b00100,
        PH_FLEN   = 5'b01000,
        PH_FDATA  = 5'b10000
    } phase_t;

    // one result item
    typedef struct packed {
        logic              result_kind;
        logic [7:0]        start_x;
        logic signed [8:0] start_y;
        logic [7:0]        end_x;
        logic signed [8:0] end_y;
        logic [7:0]        line_index;
        logic [7:0]        vector_count;
        logic              packet_status;
        logic              last;
    } result_t;

    localparam int TDATA_BITS = 56;

endpackage

/* hdl/line_vector_packet_parser.sv */
// ----------------------------------------------------------------------------
// line_vector_packet_parser
// Byte-wide parser for camera response packets that emits line vectors
// and a closing summary per packet.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock cycle while s_tready is high and gives
// at most one result per byte. Each byte is parsed by the header/feature state logic
// in the cycle it is accepted and its result, if any, is registered in the output
// register, or in the one-entry skid register behind it while the output register is
// full. The skid register lets input continue while a result waits; s_tready drops
// only while both hold a result, so the sustained rate is one byte per cycle as long
// as the consumer keeps up. A packet opens on a byte with tuser set: bytes 0..2
// must be 0xaf, 0xc1, 49, byte 3 is the payload length L, bytes 4..5 are an
// unchecked checksum and the payload ends at byte 5+L. Vectors of the
// configured line feature type give a result with y flipped to bottom origin;
// the summary (tuser set, tlast set) gives the vector count and header status.
module line_vector_packet_parser
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] packet_start

    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] start_x, [16:8] start_y, [24:17] end_x,
                                   // [33:25] end_y, [41:34] line_index,
                                   // [49:42] vector_count, [50] packet_status
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast    // last
);

    // configuration registers
    logic [7:0] line_type_reg;
    logic [7:0] frame_height_reg;
    logic [7:0] max_vectors_reg;

    // parser state
    lvpp_pkg::phase_t phase_reg, phase_next;
    logic       in_packet_reg, in_packet_next;
    logic [8:0] pos_reg, pos_next;
    logic [8:0] pend_reg, pend_next;
    logic [7:0] ftype_reg, ftype_next;
    logic [7:0] fleft_reg, fleft_next;
    logic [2:0] slot_reg, slot_next;
    logic [7:0] hsx_reg, hsx_next;
    logic [7:0] hsy_reg, hsy_next;
    logic [7:0] hex_reg, hex_next;
    logic [7:0] hey_reg, hey_next;
    logic [7:0] vfound_reg, vfound_next;

    // output register and skid
    logic                  out_valid_reg;
    lvpp_pkg::result_t     out_data_reg;
    logic                  skid_valid_reg;
    lvpp_pkg::result_t     skid_data_reg;

    logic                  accept;
    logic                  take;
    logic                  res_valid;
    lvpp_pkg::result_t     res;

    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_type_reg    <= lvpp_pkg::LINE_FEATURE_TYPE_RST;
            frame_height_reg <= lvpp_pkg::FRAME_HEIGHT_RST;
            max_vectors_reg  <= lvpp_pkg::MAX_VECTORS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                lvpp_pkg::REG_LINE_FEATURE_TYPE: line_type_reg    <= cfg_data;
                lvpp_pkg::REG_FRAME_HEIGHT:      frame_height_reg <= cfg_data;
                lvpp_pkg::REG_MAX_VECTORS:       max_vectors_reg  <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // byte parsing
    always_comb
    begin
        lvpp_pkg::phase_t cur_phase;
        logic [7:0] b;
        logic [8:0] p;
        logic [9:0] p_inc;
        logic [7:0] fleft_dec;
        logic       mismatch;

        b         = s_tdata;
        phase_next     = phase_reg;
        in_packet_next = in_packet_reg;
        pos_next       = pos_reg;
        pend_next      = pend_reg;
        ftype_next     = ftype_reg;
        fleft_next     = fleft_reg;
        slot_next      = slot_reg;
        hsx_next       = hsx_reg;
        hsy_next       = hsy_reg;
        hex_next       = hex_reg;
        hey_next       = hey_reg;
        vfound_next    = vfound_reg;
        res_valid      = 1'b0;
        res            = '0;
        cur_phase      = phase_reg;
        p              = pos_reg;
        p_inc          = 10'd0;
        fleft_dec      = 8'd0;
        mismatch       = 1'b0;

        if (accept)
        begin
            // start of packet resets the per-packet state
            if (s_tuser)
            begin
                in_packet_next = 1'b1;
                pos_next       = 9'd0;
                pend_next      = 9'd0;
                phase_next     = lvpp_pkg::PH_HEADER;
                vfound_next    = 8'd0;
                fleft_next     = 8'd0;
                slot_next      = 3'd0;
                ftype_next     = 8'd0;
            end

            if (in_packet_next)
            begin
                cur_phase = phase_next;
                p         = pos_next;
                p_inc     = {1'b0, p} + 10'd1;
                mismatch  = ((p == lvpp_pkg::POS_SYNC_A) && (b != lvpp_pkg::SYNC_A)) ||
                            ((p == lvpp_pkg::POS_SYNC_B) && (b != lvpp_pkg::SYNC_B)) ||
                            ((p == lvpp_pkg::POS_TYPE)   && (b != lvpp_pkg::RESP_TYPE));

                if ((cur_phase == lvpp_pkg::PH_HEADER) && mismatch)
                begin
                    // bad header: close at once with error status
                    res_valid            = 1'b1;
                    res.result_kind      = lvpp_pkg::KIND_SUMMARY;
                    res.vector_count     = vfound_next;
                    res.packet_status    = lvpp_pkg::STATUS_BAD_HDR;
                    res.last             = 1'b1;
                    in_packet_next       = 1'b0;
                    phase_next           = lvpp_pkg::PH_IDLE;
                end
                else
                begin
                    unique case (cur_phase)
                        lvpp_pkg::PH_HEADER:
                        begin
                            if (p == lvpp_pkg::POS_LENGTH)
                                pend_next = lvpp_pkg::PAYLOAD_START + {1'b0, b};
                            if (p == lvpp_pkg::POS_HDR_END)
                                phase_next = lvpp_pkg::PH_FTYPE;
                        end
                        lvpp_pkg::PH_FTYPE:
                        begin
                            ftype_next = b;
                            phase_next = lvpp_pkg::PH_FLEN;
                        end
                        lvpp_pkg::PH_FLEN:
                        begin
                            fleft_next = b;
                            slot_next  = 3'd0;
                            phase_next = (b == 8'd0) ? lvpp_pkg::PH_FTYPE
                                                     : lvpp_pkg::PH_FDATA;
                        end
                        lvpp_pkg::PH_FDATA:
                        begin
                            fleft_dec  = fleft_next - 8'd1;
                            fleft_next = fleft_dec;
                            if (ftype_next == line_type_reg)
                            begin
                                unique case (slot_next)
                                    lvpp_pkg::SLOT_START_X: hsx_next = b;
                                    lvpp_pkg::SLOT_START_Y: hsy_next = b;
                                    lvpp_pkg::SLOT_END_X:   hex_next = b;
                                    lvpp_pkg::SLOT_END_Y:   hey_next = b;
                                    lvpp_pkg::SLOT_INDEX:
                                    begin
                                        // whole vector inside feature and payload, count below max_vectors
                                        if ((fleft_dec != 8'd0) &&
                                            (p_inc < {1'b0, pend_next}) &&
                                            (vfound_next < max_vectors_reg))
                                        begin
                                            vfound_next       = vfound_next + 8'd1;
                                            res_valid         = 1'b1;
                                            res.result_kind   = lvpp_pkg::KIND_VECTOR;
                                            res.start_x       = hsx_next;
                                            res.start_y       = {1'b0, frame_height_reg}
                                                              - {1'b0, hsy_next};
                                            res.end_x         = hex_next;
                                            res.end_y         = {1'b0, frame_height_reg}
                                                              - {1'b0, hey_next};
                                            res.line_index    = b;
                                            res.vector_count  = vfound_next;
                                            res.packet_status = lvpp_pkg::STATUS_OK;
                                            res.last          = 1'b0;
                                        end
                                    end
                                    default: ;
                                endcase
                                slot_next = (slot_next >= lvpp_pkg::SLOT_FLAGS) ? 3'd0
                                                                              : slot_next + 3'd1;
                            end
                            if (fleft_dec == 8'd0)
                                phase_next = lvpp_pkg::PH_FTYPE;
                        end
                        default: ;
                    endcase

                    // payload end closes the packet
                    if ((p >= lvpp_pkg::POS_HDR_END) && (p_inc >= {1'b0, pend_next}))
                    begin
                        res_valid         = 1'b1;
                        res               = '0;
                        res.result_kind   = lvpp_pkg::KIND_SUMMARY;
                        res.vector_count  = vfound_next;
                        res.packet_status = lvpp_pkg::STATUS_OK;
                        res.last          = 1'b1;
                        in_packet_next    = 1'b0;
                        phase_next        = lvpp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        pos_next = p_inc[8:0];
                    end
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lvpp_pkg::PH_IDLE;
            in_packet_reg <= 1'b0;
            pos_reg       <= 9'd0;
            pend_reg      <= 9'd0;
            ftype_reg     <= 8'd0;
            fleft_reg     <= 8'd0;
            slot_reg      <= 3'd0;
            hsx_reg       <= 8'd0;
            hsy_reg       <= 8'd0;
            hex_reg       <= 8'd0;
            hey_reg       <= 8'd0;
            vfound_reg    <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            in_packet_reg <= in_packet_next;
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            ftype_reg     <= ftype_next;
            fleft_reg     <= fleft_next;
            slot_reg      <= slot_next;
            hsx_reg       <= hsx_next;
            hsy_reg       <= hsy_next;
            hex_reg       <= hex_next;
            hey_reg       <= hey_next;
            vfound_reg    <= vfound_next;
        end
    end

    // output register with one-entry skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_data_reg <= skid_data_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || take)
                out_data_reg <= res;
            else
                skid_data_reg <= res;
        end
    end

    // port packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.result_kind;
    assign m_tlast  = out_data_reg.last;
    assign m_tdata  = {5'd0,
                       out_data_reg.packet_status,
                       out_data_reg.vector_count,
                       out_data_reg.line_index,
                       out_data_reg.end_y,
                       out_data_reg.end_x,
                       out_data_reg.start_y,
                       out_data_reg.start_x};

    // checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_phase_tracks_packet: assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg == (phase_reg != lvpp_pkg::PH_IDLE))
        else $error("parse phase disagrees with open packet flag");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= lvpp_pkg::SLOT_FLAGS)
        else $error("vector byte slot out of range");

    a_summary_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && (res.result_kind == lvpp_pkg::KIND_SUMMARY))
        |=> !in_packet_reg)
        else $error("packet still open after its summary");

    a_vector_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && (res.result_kind == lvpp_pkg::KIND_VECTOR))
        |=> (vfound_reg == $past(vfound_next)) && (vfound_reg != 8'd0))
        else $error("vector emitted without count update");

endmodule
